@@ sv/bounded_change_making_macros.svh @@
// assertion macros for the bounded change making block
`ifndef BOUNDED_CHANGE_MAKING_MACROS_SVH
`define BOUNDED_CHANGE_MAKING_MACROS_SVH

// same-cycle implication under active-low reset
`define BCM_ASSERT_IMPL(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (lhs) |-> (rhs)) \
        else $error("bcm assertion failed");

// next-cycle implication under active-low reset
`define BCM_ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (lhs) |=> (rhs)) \
        else $error("bcm assertion failed");

`endif

@@ sv/bcm_pkg.sv @@
// shared types and constants for the bounded change making block
`timescale 1ns / 1ps
`default_nettype none

package bcm_pkg;

    localparam int NUM_TYPES  = 4;
    localparam int MAX_STOCK  = 15;
    localparam int VALUE_W    = 10;
    localparam int STOCK_W    = 4;
    localparam int TARGET_W   = 16;
    localparam int TYPE_IDX_W = 2;
    localparam int CFG_IDX_W  = 4;
    localparam int PROD_W     = 14;
    localparam int SUM_W      = 16;
    localparam int TOTAL_W    = 6;

    typedef logic [VALUE_W-1:0]  value_t;
    typedef logic [STOCK_W-1:0]  count_t;
    typedef logic [PROD_W-1:0]   prod_t;
    typedef logic [SUM_W-1:0]    sum_t;
    typedef logic [TOTAL_W-1:0]  total_t;
    typedef logic [TARGET_W-1:0] target_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    typedef value_t [NUM_TYPES-1:0] value_vec_t;
    typedef count_t [NUM_TYPES-1:0] count_vec_t;
    typedef prod_t  [NUM_TYPES-1:0] prod_vec_t;

    // register map
    localparam cfg_idx_t CFG_VALUE_BASE = 4'd0;
    localparam cfg_idx_t CFG_STOCK_BASE = 4'd4;
    localparam cfg_idx_t CFG_END        = 4'd8;

    localparam value_vec_t VALUE_RESET = {10'd10, 10'd5, 10'd2, 10'd1};

    // sequencer controls to the datapath
    typedef struct packed {
        logic start;
        logic step;
    } ctrl_t;

endpackage

`default_nettype wire

@@ sv/bcm_cfg.sv @@
// configuration registers: denominations and stock counts
`timescale 1ns / 1ps
`default_nettype none

module bcm_cfg (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_we,
    input  wire bcm_pkg::cfg_idx_t   cfg_index,
    input  wire bcm_pkg::value_t     cfg_data,
    output bcm_pkg::value_vec_t      coin_value,
    output bcm_pkg::count_vec_t      stock
);

    bcm_pkg::value_vec_t value_reg;
    bcm_pkg::count_vec_t stock_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            value_reg <= bcm_pkg::VALUE_RESET;
            stock_reg <= '0;
        end
        else if (cfg_we)
        begin
            if (cfg_index < bcm_pkg::CFG_STOCK_BASE)
            begin
                value_reg[cfg_index[bcm_pkg::TYPE_IDX_W-1:0]] <= cfg_data;
            end
            else if (cfg_index < bcm_pkg::CFG_END)
            begin
                stock_reg[cfg_index[bcm_pkg::TYPE_IDX_W-1:0]] <=
                    cfg_data[bcm_pkg::STOCK_W-1:0];
            end
        end
    end

    assign coin_value = value_reg;
    assign stock      = stock_reg;

endmodule

`default_nettype wire

@@ sv/bcm_odo.sv @@
// odometer over all count combinations with running per-type products
`timescale 1ns / 1ps
`default_nettype none

module bcm_odo (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire bcm_pkg::ctrl_t      ctrl,
    input  wire bcm_pkg::value_vec_t coin_value,
    input  wire bcm_pkg::count_vec_t stock,
    output bcm_pkg::count_vec_t      cur,
    output bcm_pkg::prod_vec_t       prod,
    output logic                     last
);

    bcm_pkg::count_vec_t cur_reg;
    bcm_pkg::count_vec_t cur_next;
    bcm_pkg::prod_vec_t  prod_reg;
    bcm_pkg::prod_vec_t  prod_next;
    bcm_pkg::count_vec_t lim;
    logic                carry;

    // per-type limit, clamped, unused types held at zero
    always_comb
    begin
        for (int i = 0; i < bcm_pkg::NUM_TYPES; i++)
        begin
            if (stock[i] > bcm_pkg::count_t'(bcm_pkg::MAX_STOCK))
                lim[i] = bcm_pkg::count_t'(bcm_pkg::MAX_STOCK);
            else
                lim[i] = stock[i];
        end
    end

    always_comb
    begin
        last = 1'b1;
        for (int i = 0; i < bcm_pkg::NUM_TYPES; i++)
        begin
            if (cur_reg[i] < lim[i])
                last = 1'b0;
        end
    end

    always_comb
    begin
        cur_next  = cur_reg;
        prod_next = prod_reg;
        carry     = 1'b1;
        if (ctrl.start)
        begin
            cur_next  = '0;
            prod_next = '0;
        end
        else if (ctrl.step)
        begin
            for (int i = 0; i < bcm_pkg::NUM_TYPES; i++)
            begin
                if (carry)
                begin
                    if (cur_reg[i] < lim[i])
                    begin
                        cur_next[i]  = bcm_pkg::count_t'(cur_reg[i] + 1'b1);
                        prod_next[i] = bcm_pkg::prod_t'(prod_reg[i]
                                       + bcm_pkg::prod_t'(coin_value[i]));
                        carry        = 1'b0;
                    end
                    else
                    begin
                        cur_next[i]  = '0;
                        prod_next[i] = '0;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg  <= '0;
            prod_reg <= '0;
        end
        else
        begin
            cur_reg  <= cur_next;
            prod_reg <= prod_next;
        end
    end

    assign cur  = cur_reg;
    assign prod = prod_reg;

endmodule

`default_nettype wire

@@ sv/bcm_eval.sv @@
// shared sum and compare unit with best-so-far registers
`timescale 1ns / 1ps
`default_nettype none

module bcm_eval (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire bcm_pkg::ctrl_t      ctrl,
    input  wire bcm_pkg::target_t    target,
    input  wire bcm_pkg::count_vec_t cur,
    input  wire bcm_pkg::prod_vec_t  prod,
    output logic                     have,
    output bcm_pkg::count_vec_t      best
);

    bcm_pkg::sum_t       sum;
    bcm_pkg::total_t     total;
    logic                hit;
    logic                have_reg;
    bcm_pkg::total_t     best_total_reg;
    bcm_pkg::count_vec_t best_reg;

    always_comb
    begin
        sum   = '0;
        total = '0;
        for (int i = 0; i < bcm_pkg::NUM_TYPES; i++)
        begin
            sum   = bcm_pkg::sum_t'(sum + bcm_pkg::sum_t'(prod[i]));
            total = bcm_pkg::total_t'(total + bcm_pkg::total_t'(cur[i]));
        end
    end

    // later equal-total candidates always lose the tie, so strict less is enough
    assign hit = ctrl.step && (target != '0) && (sum == target)
                 && (!have_reg || (total < best_total_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_reg       <= 1'b0;
            best_total_reg <= '0;
            best_reg       <= '0;
        end
        else if (ctrl.start)
        begin
            have_reg       <= 1'b0;
            best_total_reg <= '0;
            best_reg       <= '0;
        end
        else if (hit)
        begin
            have_reg       <= 1'b1;
            best_total_reg <= total;
            best_reg       <= cur;
        end
    end

    assign have = have_reg;
    assign best = best_reg;

endmodule

`default_nettype wire

@@ sv/bounded_change_making.sv @@
// top level: sequencer, input capture and result register
`timescale 1ns / 1ps
`default_nettype none

// Exact change with the fewest coins from a bounded stock. Each target walks every
// combination of per-type counts (0..stock) through one shared sum and compare unit,
// one combination per clock; the finish state then waits until the result register
// is free. in_stall is high during the walk and the finish; a finished result waits
// in the output register and the next target is accepted meanwhile. A zero target
// or no exact match gives found=0 and all counts zero. Ties in coin total go to
// fewer coins of the highest type. Configuration writes are taken any time but must
// only be made while idle.

`include "bounded_change_making_macros.svh"

module bounded_change_making (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire bcm_pkg::cfg_idx_t    cfg_index,
    input  wire bcm_pkg::value_t      cfg_data,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire bcm_pkg::target_t     target,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic                      found,
    output bcm_pkg::count_t           count_0,
    output bcm_pkg::count_t           count_1,
    output bcm_pkg::count_t           count_2,
    output bcm_pkg::count_t           count_3
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_FINISH
    } state_t;

    state_t              state_reg;
    bcm_pkg::target_t    target_reg;
    logic                out_valid_reg;
    logic                found_reg;
    bcm_pkg::count_vec_t count_reg;

    bcm_pkg::ctrl_t      ctrl;
    bcm_pkg::value_vec_t coin_value;
    bcm_pkg::count_vec_t stock;
    bcm_pkg::count_vec_t cur;
    bcm_pkg::prod_vec_t  prod;
    logic                last;
    logic                have;
    bcm_pkg::count_vec_t best;
    logic                in_take;
    logic                out_free;

    assign in_take  = in_valid && (state_reg == ST_IDLE);
    assign out_free = !out_valid_reg || !out_stall;

    assign ctrl = '{start: in_take, step: (state_reg == ST_SEARCH)};

    bcm_cfg u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .coin_value (coin_value),
        .stock      (stock)
    );

    bcm_odo u_odo (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .coin_value (coin_value),
        .stock      (stock),
        .cur        (cur),
        .prod       (prod),
        .last       (last)
    );

    bcm_eval u_eval (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (ctrl),
        .target (target_reg),
        .cur    (cur),
        .prod   (prod),
        .have   (have),
        .best   (best)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            target_reg    <= '0;
            out_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
            count_reg     <= '0;
        end
        else
        begin
            if (out_valid_reg && !out_stall && (state_reg != ST_FINISH))
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_take)
                    begin
                        target_reg <= target;
                        state_reg  <= ST_SEARCH;
                    end
                end
                ST_SEARCH:
                begin
                    if (last)
                        state_reg <= ST_FINISH;
                end
                ST_FINISH:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        found_reg     <= have;
                        count_reg     <= have ? best : '0;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign found     = found_reg;
    assign count_0   = count_reg[0];
    assign count_1   = count_reg[1];
    assign count_2   = count_reg[2];
    assign count_3   = count_reg[3];

    `BCM_ASSERT_NEXT(a_take_starts_search, clk, rst_n, in_valid && !in_stall, in_stall)
    `BCM_ASSERT_IMPL(a_found_has_coins, clk, rst_n, out_valid && found,
        (count_0 | count_1 | count_2 | count_3) != '0)
    `BCM_ASSERT_IMPL(a_miss_is_zero, clk, rst_n, out_valid && !found,
        (count_0 | count_1 | count_2 | count_3) == '0)
    `BCM_ASSERT_NEXT(a_finish_waits, clk, rst_n,
        (state_reg == ST_FINISH) && out_valid_reg && out_stall, out_valid_reg)

endmodule

`default_nettype wire

@@ tb/bounded_change_making_test.sv @@
// self-checking testbench for the bounded change making block
`timescale 1ns / 1ps

module bounded_change_making_test;

    import bcm_pkg::*;

    localparam int ITEMS_PER_PHASE = 12;
    localparam int RANDOM_PHASES   = 8;
    localparam int HOLD_AT         = 20;
    localparam int HOLD_CYCLES     = 3000;
    localparam int DRAIN_CYCLES    = 100;
    localparam cfg_idx_t TOP_INDEX = '1;

    typedef struct packed {
        target_t    target;
        logic       found;
        count_vec_t counts;
    } change_t;

    class change_checker;
        value_t    coin_value [NUM_TYPES];
        count_t    stock [NUM_TYPES];
        change_t   due_changes [$];
        int        errors;

        function new();
            for (int i = 0; i < NUM_TYPES; i++)
            begin
                coin_value[i] = VALUE_RESET[i];
                stock[i]      = '0;
            end
            errors = 0;
        endfunction

        function void set_reg(cfg_idx_t idx, value_t data);
            if (idx < CFG_STOCK_BASE)
            begin
                coin_value[idx - CFG_VALUE_BASE] = data;
            end
            else if (idx < CFG_END)
            begin
                stock[idx - CFG_STOCK_BASE] = data[STOCK_W-1:0];
            end
        endfunction

        // fewest coins, then fewest of the highest type downward
        function change_t best_change(target_t t);
            change_t    r;
            count_vec_t cand;
            int         best_total;
            int         sum;
            int         total;
            r.target   = t;
            r.found    = 1'b0;
            r.counts   = '0;
            best_total = 0;
            if (t != 0)
            begin
                for (int c3 = 0; c3 <= stock[3]; c3++)
                    for (int c2 = 0; c2 <= stock[2]; c2++)
                        for (int c1 = 0; c1 <= stock[1]; c1++)
                            for (int c0 = 0; c0 <= stock[0]; c0++)
                            begin
                                sum = c0 * coin_value[0] + c1 * coin_value[1]
                                    + c2 * coin_value[2] + c3 * coin_value[3];
                                total = c0 + c1 + c2 + c3;
                                cand = {count_t'(c3), count_t'(c2), count_t'(c1),
                                        count_t'(c0)};
                                if (sum == t && (!r.found || total < best_total
                                    || (total == best_total && cand < r.counts)))
                                begin
                                    r.found    = 1'b1;
                                    r.counts   = cand;
                                    best_total = total;
                                end
                            end
            end
            return r;
        endfunction

        function void note_target(target_t t);
            due_changes.insert(due_changes.size(), best_change(t));
        endfunction

        function int pending();
            return due_changes.size();
        endfunction

        function void field_check(string name, target_t t, int exp_val, int act_val);
            if (exp_val != act_val)
            begin
                $display("%0t: target %0d %s expected %0d actual %0d",
                         $time, t, name, exp_val, act_val);
                errors++;
            end
        endfunction

        function void check_change(logic f, count_vec_t c);
            change_t e;
            if (due_changes.size() == 0)
            begin
                $display("%0t: unexpected result expected none actual found=%0d counts=%h",
                         $time, f, c);
                errors++;
                return;
            end
            e = due_changes.pop_front();
            field_check("found", e.target, e.found, f);
            for (int i = 0; i < NUM_TYPES; i++)
                field_check($sformatf("count_%0d", i), e.target, e.counts[i], c[i]);
        endfunction
    endclass

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     cfg_we = 1'b0;
    cfg_idx_t cfg_index = '0;
    value_t   cfg_data = '0;
    logic     in_valid = 1'b0;
    logic     in_stall;
    target_t  target = '0;
    logic     out_valid;
    logic     out_stall = 1'b0;
    logic     found;
    count_t   count_0;
    count_t   count_1;
    count_t   count_2;
    count_t   count_3;

    change_checker book = new();
    logic          quiet = 1'b0;
    int            results_seen = 0;
    int            hold_left = 0;

    bounded_change_making dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .target    (target),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .found     (found),
        .count_0   (count_0),
        .count_1   (count_1),
        .count_2   (count_2),
        .count_3   (count_3)
    );

    always #5 clk = ~clk;

    initial
    begin
        #20_000_000;
        $display("FAIL");
        $finish;
    end

    // result side: random stalls plus one long hold-off
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                book.check_change(found, {count_3, count_2, count_1, count_0});
                results_seen++;
                if (results_seen == HOLD_AT)
                    hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0)
                hold_left--;
            out_stall <= (hold_left != 0) || (!quiet && $urandom_range(0, 99) < 11);
        end
    end

    task automatic write_reg(input cfg_idx_t idx, input value_t data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        book.set_reg(idx, data);
    endtask

    task automatic load_config(input value_vec_t v, input count_vec_t s);
        for (int i = 0; i < NUM_TYPES; i++)
            write_reg(cfg_idx_t'(CFG_VALUE_BASE + i), v[i]);
        for (int i = 0; i < NUM_TYPES; i++)
            write_reg(cfg_idx_t'(CFG_STOCK_BASE + i), value_t'(s[i]));
        cfg_we <= 1'b0;
    endtask

    task automatic send_target(input target_t t);
        if (!quiet)
        begin
            while ($urandom_range(0, 99) < 11)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
        in_valid <= 1'b1;
        target   <= t;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        book.note_target(t);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (book.pending() != 0)
            @(posedge clk);
    endtask

    task automatic run_random_phase(input logic calm);
        value_vec_t v;
        count_vec_t s;
        int         sum;
        int         pick;
        for (int i = 0; i < NUM_TYPES; i++)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 6)
                v[i] = value_t'($urandom_range(1, 20));
            else if (pick < 8)
                v[i] = value_t'($urandom_range(1, 1023));
            else if (pick == 8)
                v[i] = '0;
            else if (i == 0)
                v[i] = value_t'(1023);
            else
                v[i] = v[i-1];
        end
        for (int i = 0; i < NUM_TYPES; i++)
            s[i] = count_t'($urandom_range(0, 3));
        if ($urandom_range(0, 3) == 0)
            s[$urandom_range(0, NUM_TYPES - 1)] = count_t'($urandom_range(4, 15));
        load_config(v, s);
        quiet = calm;
        repeat (ITEMS_PER_PHASE)
        begin
            sum = 0;
            for (int i = 0; i < NUM_TYPES; i++)
                sum += $urandom_range(0, s[i]) * v[i];
            pick = $urandom_range(0, 9);
            if (pick == 7)
                send_target(target_t'($urandom));
            else if (pick == 8)
                send_target(target_t'(sum + 1));
            else if (pick == 9)
                send_target('0);
            else
                send_target(target_t'(sum));
        end
        wait_idle();
        quiet = 1'b0;
    endtask

    initial
    begin : stimulus
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: no stock at all
        send_target('0);
        send_target(target_t'(1));
        send_target('1);
        wait_idle();

        // reset denominations with a few coins each
        for (int i = 0; i < NUM_TYPES; i++)
            write_reg(cfg_idx_t'(CFG_STOCK_BASE + i), value_t'(3));
        cfg_we <= 1'b0;
        send_target('0);
        send_target(target_t'(17));
        send_target(target_t'(18));
        send_target(target_t'(4));
        send_target(target_t'(54));
        send_target(target_t'(55));
        send_target('1);
        wait_idle();

        // full stock, largest and equal denominations, a zero denomination
        load_config({10'd0, 10'd1, 10'd1023, 10'd1023},
                    {4'd15, 4'd15, 4'd15, 4'd15});
        send_target(target_t'(1028));
        send_target(target_t'(2046));
        send_target(target_t'(30705));
        wait_idle();

        // wide data masked to the stock width, writes past the map ignored
        write_reg(cfg_idx_t'(CFG_VALUE_BASE + 0), value_t'(3));
        write_reg(cfg_idx_t'(CFG_VALUE_BASE + 1), value_t'(7));
        write_reg(cfg_idx_t'(CFG_VALUE_BASE + 2), value_t'(7));
        write_reg(cfg_idx_t'(CFG_VALUE_BASE + 3), value_t'(200));
        write_reg(cfg_idx_t'(CFG_STOCK_BASE + 0), 10'h3F2);
        write_reg(cfg_idx_t'(CFG_STOCK_BASE + 1), 10'h2C1);
        write_reg(cfg_idx_t'(CFG_STOCK_BASE + 2), 10'h153);
        write_reg(cfg_idx_t'(CFG_STOCK_BASE + 3), 10'h0A2);
        write_reg(CFG_END, 10'h3FF);
        write_reg(TOP_INDEX, 10'h2AA);
        cfg_we <= 1'b0;
        send_target(target_t'(14));
        send_target(target_t'(206));
        send_target(target_t'(413));
        send_target(target_t'(9));
        send_target('0);
        send_target('1);
        wait_idle();

        for (int p = 0; p < RANDOM_PHASES; p++)
            run_random_phase(p == 3);

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (book.errors == 0 && book.pending() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
